@@ rtl/core/idr_pkg.sv @@
// ----------------------------------------------------------------------------
// idr_pkg
// Shared constants, codes and types of the image download receiver.
// ----------------------------------------------------------------------------
package idr_pkg;

    // sizing
    localparam int BUF_ADDR_BITS = 24;
    localparam int SEQ_BITS      = 16;
    localparam int MAX_PAYLOAD   = 1500;
    localparam int PLEN_W        = 11;
    localparam int INFO_W        = 16;
    localparam int TIMER_W       = 16;
    localparam int RETRY_W       = 8;
    localparam int MAC_W         = 48;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    // request types on the input channel
    localparam logic [1:0] REQ_PACKET = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_FDONE  = 2'd2;

    // request kinds after classification
    localparam logic [1:0] KIND_PACKET = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_FDONE  = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    // packet commands
    localparam logic [2:0] CMD_RESET   = 3'd0;
    localparam logic [2:0] CMD_REQUEST = 3'd1;
    localparam logic [2:0] CMD_END     = 3'd2;
    localparam logic [2:0] CMD_IMAGE   = 3'd3;
    localparam logic [2:0] CMD_QUERY   = 3'd4;

    // download states
    localparam logic [2:0] ST_NONE  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_GET   = 3'd2;
    localparam logic [2:0] ST_WRITE = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;
    localparam logic [2:0] ST_ABORT = 3'd5;

    // acknowledgement error codes
    localparam logic [2:0] ERR_OK    = 3'd0;
    localparam logic [2:0] ERR_STATE = 3'd1;
    localparam logic [2:0] ERR_SEQ   = 3'd2;
    localparam logic [2:0] ERR_CSUM  = 3'd3;
    localparam logic [2:0] ERR_CMD   = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_IDLE_TIMEOUT  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_RETRY_LIMIT   = 2'd2;

    // configuration reset values
    localparam logic [TIMER_W-1:0] IDLE_TIMEOUT_RST  = TIMER_W'(100);
    localparam logic [TIMER_W-1:0] IMAGE_TIMEOUT_RST = TIMER_W'(100);
    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST   = RETRY_W'(5);

    // classified request as it travels through the queue
    typedef struct packed {
        logic [1:0]          kind;
        logic [2:0]          cmd;
        logic [SEQ_BITS-1:0] seq;
        logic [PLEN_W-1:0]   plen;
        logic                csum_bad;
        logic [MAC_W-1:0]    src;
    } t_item;

    // configuration registers
    typedef struct packed {
        logic [TIMER_W-1:0] idle_timeout;
        logic [TIMER_W-1:0] image_timeout;
        logic [RETRY_W-1:0] retry_limit;
    } t_cfg;

    // one result
    typedef struct packed {
        logic                     ack_valid;
        logic [2:0]               ack_command;
        logic [2:0]               ack_error;
        logic [INFO_W-1:0]        ack_info;
        logic                     accept_payload;
        logic [BUF_ADDR_BITS-1:0] write_offset;
        logic [BUF_ADDR_BITS-1:0] total_length;
        logic                     start_flash_write;
        logic [2:0]               download_state;
        logic [MAC_W-1:0]         peer_addr;
    } t_result;

endpackage

@@ rtl/core/image_download_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// image_download_receiver_unit
// Receiver of a firmware download protocol: packet, tick and flash-done
// requests in, one result with acknowledgement and status per request out.
// ----------------------------------------------------------------------------
// path: request accept to result valid passes the front register, the
//   two-entry queue and the result register in the execution stage
// throughput: one request per cycle unless the result channel stalls; the
//   execution stage updates all state together as it takes a request
// reset: synchronous, clears download state, counters and queue; timeouts
//   return to 100 ticks and the retry limit to 5
module image_download_receiver_unit import idr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [1:0]               i_cfg_index,
    input  logic [15:0]              i_cfg_data,
    // request channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_req_type,
    input  logic [2:0]               i_command,
    input  logic [15:0]              i_seq_num,
    input  logic [PLEN_W-1:0]        i_payload_len,
    input  logic                     i_checksum_bad,
    input  logic [MAC_W-1:0]         i_source_addr,
    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_ack_valid,
    output logic [2:0]               o_ack_command,
    output logic [2:0]               o_ack_error,
    output logic [INFO_W-1:0]        o_ack_info,
    output logic                     o_accept_payload,
    output logic [BUF_ADDR_BITS-1:0] o_write_offset,
    output logic [BUF_ADDR_BITS-1:0] o_total_length,
    output logic                     o_start_flash_write,
    output logic [2:0]               o_download_state,
    output logic [MAC_W-1:0]         o_peer_addr
);

    t_cfg    r_cfg;
    logic    push_valid;
    logic    push_ready;
    t_item   push_item;
    logic    pop_valid;
    logic    pop_ready;
    t_item   pop_item;
    t_result res;

    // configuration registers, written only with no request in flight
    assign o_cfg_ready = !push_valid && !pop_valid && !o_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_timeout  <= IDLE_TIMEOUT_RST;
            r_cfg.image_timeout <= IMAGE_TIMEOUT_RST;
            r_cfg.retry_limit   <= RETRY_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IDLE_TIMEOUT:  r_cfg.idle_timeout  <= i_cfg_data;
                CFG_IMAGE_TIMEOUT: r_cfg.image_timeout <= i_cfg_data;
                CFG_RETRY_LIMIT:   r_cfg.retry_limit   <= i_cfg_data[RETRY_W-1:0];
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    // request classification
    idr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_command      (i_command),
        .i_seq_num      (i_seq_num),
        .i_payload_len  (i_payload_len),
        .i_checksum_bad (i_checksum_bad),
        .i_source_addr  (i_source_addr),
        .o_push_valid   (push_valid),
        .i_push_ready   (push_ready),
        .o_push_item    (push_item)
    );

    // request queue
    idr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_item   (pop_item)
    );

    // execution
    idr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_item      (pop_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (res)
    );

    // result fields
    assign o_ack_valid         = res.ack_valid;
    assign o_ack_command       = res.ack_command;
    assign o_ack_error         = res.ack_error;
    assign o_ack_info          = res.ack_info;
    assign o_accept_payload    = res.accept_payload;
    assign o_write_offset      = res.write_offset;
    assign o_total_length      = res.total_length;
    assign o_start_flash_write = res.start_flash_write;
    assign o_download_state    = res.download_state;
    assign o_peer_addr         = res.peer_addr;

    // flash programming starts only from the write flash state
    a_flash_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_start_flash_write |-> o_download_state == ST_WRITE)
        else $error("flash start outside write flash state");

    // no acknowledgement means empty acknowledgement fields
    a_ack_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_ack_valid |->
            o_ack_command == '0 && o_ack_error == ERR_OK && o_ack_info == '0)
        else $error("acknowledgement fields set without acknowledgement");

    // offset only with accepted payload
    a_offset_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_accept_payload |-> o_write_offset == '0)
        else $error("write offset set without accepted payload");

    // accepted payload is an ok image request in get image state
    a_payload_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_accept_payload |->
            o_ack_valid && o_ack_error == ERR_OK && o_ack_command == CMD_IMAGE
            && o_download_state == ST_GET)
        else $error("payload accepted outside an ok image request");

endmodule

@@ rtl/core/idr_front.sv @@
// ----------------------------------------------------------------------------
// idr_front
// Input stage: takes requests, classifies them and clamps the payload length.
// ----------------------------------------------------------------------------
module idr_front import idr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_req_type,
    input  logic [2:0]          i_command,
    input  logic [15:0]         i_seq_num,
    input  logic [PLEN_W-1:0]   i_payload_len,
    input  logic                i_checksum_bad,
    input  logic [MAC_W-1:0]    i_source_addr,
    output logic                o_push_valid,
    input  logic                i_push_ready,
    output t_item               o_push_item
);

    logic  r_vld;
    t_item r_item;
    t_item n_item;
    logic  take;

    assign o_in_ready   = !r_vld || i_push_ready;
    assign take         = i_in_valid && o_in_ready;
    assign o_push_valid = r_vld;
    assign o_push_item  = r_item;

    // classify the request
    always_comb begin
        case (i_req_type)
            REQ_PACKET: n_item.kind = KIND_PACKET;
            REQ_TICK:   n_item.kind = KIND_TICK;
            REQ_FDONE:  n_item.kind = KIND_FDONE;
            default:    n_item.kind = KIND_NONE;
        endcase
        n_item.cmd      = i_command;
        n_item.seq      = i_seq_num[SEQ_BITS-1:0];
        n_item.plen     = (i_payload_len > PLEN_W'(MAX_PAYLOAD)) ? PLEN_W'(MAX_PAYLOAD)
                                                                 : i_payload_len;
        n_item.csum_bad = i_checksum_bad;
        n_item.src      = i_source_addr;
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (take) begin
            r_vld <= 1'b1;
        end else if (i_push_ready) begin
            r_vld <= 1'b0;
        end
    end

    // classified request holding register
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

endmodule

@@ rtl/core/idr_queue.sv @@
// ----------------------------------------------------------------------------
// idr_queue
// Short request queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module idr_queue import idr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_item i_push_item,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_item o_pop_item
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_item   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

endmodule

@@ rtl/core/idr_back.sv @@
// ----------------------------------------------------------------------------
// idr_back
// Executes requests: download state machine, acknowledgement, retry timer.
// ----------------------------------------------------------------------------
module idr_back import idr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_pop_valid,
    output logic    o_pop_ready,
    input  t_item   i_item,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_result
);

    localparam int ACK_W = 3 + 3 + INFO_W;

    logic [2:0]               r_state,   n_state;
    logic [SEQ_BITS-1:0]      r_exp,     n_exp;
    logic [BUF_ADDR_BITS-1:0] r_bytes,   n_bytes;
    logic [MAC_W-1:0]         r_mac,     n_mac;
    logic [ACK_W-1:0]         r_ack,     n_ack;
    logic [RETRY_W-1:0]       r_retry,   n_retry;
    logic [TIMER_W-1:0]       r_tcnt,    n_tcnt;
    logic                     r_trun,    n_trun;
    logic                     r_out_vld;
    t_result                  r_res,     n_res;

    logic                     pop;
    logic [2:0]               err;
    logic [INFO_W-1:0]        info;
    logic [BUF_ADDR_BITS:0]   sum;
    logic [TIMER_W-1:0]       arm_t;
    logic [TIMER_W-1:0]       tdec;
    logic [RETRY_W-1:0]       rdec;

    // timeout of the state the timer is armed in
    function automatic logic [TIMER_W-1:0] arm_value(input logic [2:0] st, input t_cfg cfg);
        logic [TIMER_W-1:0] t;
        t = '0;
        if (st == ST_IDLE) begin
            t = cfg.idle_timeout;
        end else if (st == ST_GET) begin
            t = cfg.image_timeout;
        end
        return t;
    endfunction

    assign o_pop_ready = !r_out_vld || i_out_ready;
    assign pop         = i_pop_valid && o_pop_ready;
    assign o_out_valid = r_out_vld;
    assign o_result    = r_res;

    assign sum  = {1'b0, r_bytes} + (BUF_ADDR_BITS + 1)'(i_item.plen);
    assign tdec = r_tcnt - 1'b1;
    assign rdec = r_retry - 1'b1;

    // request execution
    always_comb begin
        n_state = r_state;
        n_exp   = r_exp;
        n_bytes = r_bytes;
        n_mac   = r_mac;
        n_ack   = r_ack;
        n_retry = r_retry;
        n_tcnt  = r_tcnt;
        n_trun  = r_trun;
        n_res   = '0;
        err     = ERR_OK;
        info    = INFO_W'(i_item.seq);
        arm_t   = '0;

        case (i_item.kind)
            KIND_PACKET: begin
                n_trun = 1'b0;
                case (i_item.cmd)
                    CMD_RESET: begin
                        n_mac   = i_item.src;
                        n_state = ST_IDLE;
                    end
                    CMD_REQUEST: begin
                        if (r_state == ST_IDLE) begin
                            n_state = ST_GET;
                            n_exp   = SEQ_BITS'(1);
                            n_bytes = '0;
                        end else begin
                            err = ERR_STATE;
                        end
                    end
                    CMD_END: begin
                        if (r_state == ST_GET) begin
                            n_state = i_item.csum_bad ? ST_ABORT : ST_WRITE;
                            err     = i_item.csum_bad ? ERR_CSUM : ERR_OK;
                        end else begin
                            err = ERR_STATE;
                        end
                    end
                    CMD_IMAGE: begin
                        if (r_state == ST_GET) begin
                            if (r_exp == i_item.seq) begin
                                n_exp                = r_exp + 1'b1;
                                n_res.accept_payload = 1'b1;
                                n_res.write_offset   = r_bytes;
                                n_bytes = sum[BUF_ADDR_BITS] ? '1 : sum[BUF_ADDR_BITS-1:0];
                            end else begin
                                err  = ERR_SEQ;
                                info = INFO_W'(r_exp);
                            end
                        end else begin
                            err = ERR_STATE;
                        end
                    end
                    CMD_QUERY: begin
                        if (r_state == ST_DONE) begin
                            n_state = ST_IDLE;
                        end else begin
                            err = ERR_STATE;
                        end
                    end
                    default: begin
                        err = ERR_CMD;
                    end
                endcase
                if (err == ERR_STATE) begin
                    info = INFO_W'(r_state);
                end
                n_ack   = {i_item.cmd, err, info};
                n_retry = i_cfg.retry_limit;
                n_res.ack_valid = 1'b1;
                {n_res.ack_command, n_res.ack_error, n_res.ack_info} = n_ack;
                // rearm in the new state
                arm_t = arm_value(n_state, i_cfg);
                if (arm_t != '0) begin
                    n_tcnt = arm_t;
                    n_trun = 1'b1;
                end
                // abort falls back to none; write flash starts programming
                if (n_state == ST_ABORT) begin
                    n_trun  = 1'b0;
                    n_state = ST_NONE;
                end else if (n_state == ST_WRITE) begin
                    n_trun                  = 1'b0;
                    n_res.start_flash_write = 1'b1;
                end
            end
            KIND_TICK: begin
                if (r_trun) begin
                    n_tcnt = tdec;
                    if (tdec == '0) begin
                        n_trun  = 1'b0;
                        n_retry = rdec;
                        if (rdec != '0) begin
                            n_res.ack_valid = 1'b1;
                            {n_res.ack_command, n_res.ack_error, n_res.ack_info} = r_ack;
                            arm_t = arm_value(r_state, i_cfg);
                            if (arm_t != '0) begin
                                n_tcnt = arm_t;
                                n_trun = 1'b1;
                            end
                        end else begin
                            n_state = ST_ABORT;
                        end
                    end
                end
            end
            KIND_FDONE: begin
                if (r_state == ST_WRITE) begin
                    n_state = ST_DONE;
                end
            end
            default: begin
                n_state = r_state;
            end
        endcase

        n_res.total_length   = n_bytes;
        n_res.download_state = n_state;
        n_res.peer_addr      = n_mac;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_NONE;
            r_exp     <= '0;
            r_bytes   <= '0;
            r_mac     <= '0;
            r_ack     <= '0;
            r_retry   <= '0;
            r_tcnt    <= '0;
            r_trun    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (pop) begin
                r_state <= n_state;
                r_exp   <= n_exp;
                r_bytes <= n_bytes;
                r_mac   <= n_mac;
                r_ack   <= n_ack;
                r_retry <= n_retry;
                r_tcnt  <= n_tcnt;
                r_trun  <= n_trun;
            end
            if (pop) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_res <= n_res;
        end
    end

endmodule

@@ bench/idr_result_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// idr_result_checker
// Watches the request, configuration and result channels of the image
// download receiver. Keeps its own copy of the download state machine, works
// out the status expected for every accepted request and compares each
// accepted result field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module idr_result_checker import idr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration channel
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [1:0]               i_cfg_index,
    input  logic [15:0]              i_cfg_data,
    // request channel
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic [1:0]               i_req_type,
    input  logic [2:0]               i_command,
    input  logic [15:0]              i_seq_num,
    input  logic [PLEN_W-1:0]        i_payload_len,
    input  logic                     i_checksum_bad,
    input  logic [MAC_W-1:0]         i_source_addr,
    // result channel
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic                     i_ack_valid,
    input  logic [2:0]               i_ack_command,
    input  logic [2:0]               i_ack_error,
    input  logic [INFO_W-1:0]        i_ack_info,
    input  logic                     i_accept_payload,
    input  logic [BUF_ADDR_BITS-1:0] i_write_offset,
    input  logic [BUF_ADDR_BITS-1:0] i_total_length,
    input  logic                     i_start_flash_write,
    input  logic [2:0]               i_download_state,
    input  logic [MAC_W-1:0]         i_peer_addr,
    // bookkeeping for the bench top
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_checked
);

    // acknowledgement kept for resends
    typedef struct packed {
        logic [2:0]        cmd;
        logic [2:0]        err;
        logic [INFO_W-1:0] info;
    } t_held_ack;

    // configuration copy
    logic [TIMER_W-1:0] idle_to;
    logic [TIMER_W-1:0] image_to;
    logic [RETRY_W-1:0] retry_limit;

    // download state copy
    logic [2:0]               dl_state;
    logic [SEQ_BITS-1:0]      expected_seq;
    logic [BUF_ADDR_BITS-1:0] image_bytes;
    logic [MAC_W-1:0]         partner_mac;
    t_held_ack                held_ack;
    logic [RETRY_W-1:0]       retries_left;
    logic [TIMER_W-1:0]       timer_count;
    logic                     timer_on;

    // status predicted per accepted request, oldest first
    t_result predicted_status_q[$];

    // resend timer loads the timeout of the current state, zero leaves it off
    task automatic arm_resend_timer();
        logic [TIMER_W-1:0] t;
        t = (dl_state == ST_IDLE) ? idle_to : (dl_state == ST_GET) ? image_to : '0;
        if (t != '0) begin
            timer_count = t;
            timer_on    = 1'b1;
        end
    endtask

    function automatic t_result with_held_ack(input t_result r);
        r.ack_valid   = 1'b1;
        r.ack_command = held_ack.cmd;
        r.ack_error   = held_ack.err;
        r.ack_info    = held_ack.info;
        return r;
    endfunction

    // one event through the download state machine
    task automatic predict_download_event(
        input  logic [1:0]        req,
        input  logic [2:0]        cmd,
        input  logic [15:0]       seq,
        input  logic [PLEN_W-1:0] plen,
        input  logic              csum_bad,
        input  logic [MAC_W-1:0]  src,
        output t_result           res
    );
        logic [2:0]             err;
        logic [INFO_W-1:0]      info;
        logic [PLEN_W-1:0]      len;
        logic [BUF_ADDR_BITS:0] sum;
        res = '0;
        case (req)
            REQ_PACKET: begin
                err      = ERR_OK;
                info     = seq;
                timer_on = 1'b0;
                case (cmd)
                    CMD_RESET: begin
                        partner_mac = src;
                        dl_state    = ST_IDLE;
                    end
                    CMD_REQUEST: begin
                        if (dl_state == ST_IDLE) begin
                            dl_state     = ST_GET;
                            expected_seq = SEQ_BITS'(1);
                            image_bytes  = '0;
                        end else begin
                            err = ERR_STATE;
                        end
                    end
                    CMD_END: begin
                        if (dl_state != ST_GET) begin
                            err = ERR_STATE;
                        end else if (csum_bad) begin
                            err      = ERR_CSUM;
                            dl_state = ST_ABORT;
                        end else begin
                            dl_state = ST_WRITE;
                        end
                    end
                    CMD_IMAGE: begin
                        if (dl_state != ST_GET) begin
                            err = ERR_STATE;
                        end else if (seq[SEQ_BITS-1:0] != expected_seq) begin
                            err  = ERR_SEQ;
                            info = INFO_W'(expected_seq);
                        end else begin
                            expected_seq = expected_seq + 1'b1;
                            // oversized payload clips, buffer length saturates
                            len = (plen > PLEN_W'(MAX_PAYLOAD)) ? PLEN_W'(MAX_PAYLOAD)
                                                                : plen;
                            res.accept_payload = 1'b1;
                            res.write_offset   = image_bytes;
                            sum         = {1'b0, image_bytes} + (BUF_ADDR_BITS + 1)'(len);
                            image_bytes = sum[BUF_ADDR_BITS] ? '1 : sum[BUF_ADDR_BITS-1:0];
                        end
                    end
                    CMD_QUERY: begin
                        if (dl_state == ST_DONE) begin
                            dl_state = ST_IDLE;
                        end else begin
                            err = ERR_STATE;
                        end
                    end
                    default: begin
                        err = ERR_CMD;
                    end
                endcase
                if (err == ERR_STATE) begin
                    info = INFO_W'(dl_state);
                end
                held_ack.cmd  = cmd;
                held_ack.err  = err;
                held_ack.info = info;
                retries_left  = retry_limit;
                res = with_held_ack(res);
                arm_resend_timer();
                // abort falls back to none once the packet is answered
                if (dl_state == ST_ABORT) begin
                    timer_on = 1'b0;
                    dl_state = ST_NONE;
                end else if (dl_state == ST_WRITE) begin
                    timer_on = 1'b0;
                    res.start_flash_write = 1'b1;
                end
            end
            REQ_TICK: begin
                if (timer_on) begin
                    timer_count = timer_count - 1'b1;
                    if (timer_count == '0) begin
                        timer_on     = 1'b0;
                        retries_left = retries_left - 1'b1;
                        if (retries_left != '0) begin
                            res = with_held_ack(res);
                            arm_resend_timer();
                        end else begin
                            dl_state = ST_ABORT;
                        end
                    end
                end
            end
            REQ_FDONE: begin
                if (dl_state == ST_WRITE) begin
                    dl_state = ST_DONE;
                end
            end
            default: ;
        endcase
        res.total_length   = image_bytes;
        res.download_state = dl_state;
        res.peer_addr      = partner_mac;
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            o_fail_count++;
        end
    endtask

    // channel monitor: results first, then settings, then new requests
    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            idle_to      = IDLE_TIMEOUT_RST;
            image_to     = IMAGE_TIMEOUT_RST;
            retry_limit  = RETRY_LIMIT_RST;
            dl_state     = ST_NONE;
            expected_seq = '0;
            image_bytes  = '0;
            partner_mac  = '0;
            held_ack     = '0;
            retries_left = '0;
            timer_count  = '0;
            timer_on     = 1'b0;
            predicted_status_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (predicted_status_q.size() == 0) begin
                    $error("result accepted with no request outstanding");
                    o_fail_count++;
                end else begin
                    want = predicted_status_q.pop_front();
                    compare_field("ack_valid", want.ack_valid, i_ack_valid);
                    compare_field("ack_command", want.ack_command, i_ack_command);
                    compare_field("ack_error", want.ack_error, i_ack_error);
                    compare_field("ack_info", want.ack_info, i_ack_info);
                    compare_field("accept_payload", want.accept_payload, i_accept_payload);
                    compare_field("write_offset", want.write_offset, i_write_offset);
                    compare_field("total_length", want.total_length, i_total_length);
                    compare_field("start_flash_write", want.start_flash_write,
                                  i_start_flash_write);
                    compare_field("download_state", want.download_state, i_download_state);
                    compare_field("peer_addr", want.peer_addr, i_peer_addr);
                end
                o_checked++;
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IDLE_TIMEOUT:  idle_to     = i_cfg_data;
                    CFG_IMAGE_TIMEOUT: image_to    = i_cfg_data;
                    CFG_RETRY_LIMIT:   retry_limit = i_cfg_data[RETRY_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                predict_download_event(i_req_type, i_command, i_seq_num, i_payload_len,
                                       i_checksum_bad, i_source_addr, want);
                predicted_status_q.push_back(want);
            end
        end
        o_pending = predicted_status_q.size();
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the image download receiver with directed protocol cases, random
// download sessions mixed with noise, and one back-to-back image transfer,
// under several timeout and retry settings with random idling on both
// channels.
// ----------------------------------------------------------------------------
module tb_top;
    import idr_pkg::*;

    // codes outside the protocol's named set
    localparam logic [1:0] REQ_UNUSED     = 2'd3;
    localparam logic [2:0] CMD_UNKNOWN_LO = 3'd5;
    localparam logic [2:0] CMD_UNKNOWN_HI = 3'd7;
    localparam int         LONG_IMAGES    = 40;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [1:0]               i_cfg_index;
    logic [15:0]              i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [1:0]               i_req_type;
    logic [2:0]               i_command;
    logic [15:0]              i_seq_num;
    logic [PLEN_W-1:0]        i_payload_len;
    logic                     i_checksum_bad;
    logic [MAC_W-1:0]         i_source_addr;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic                     o_ack_valid;
    logic [2:0]               o_ack_command;
    logic [2:0]               o_ack_error;
    logic [INFO_W-1:0]        o_ack_info;
    logic                     o_accept_payload;
    logic [BUF_ADDR_BITS-1:0] o_write_offset;
    logic [BUF_ADDR_BITS-1:0] o_total_length;
    logic                     o_start_flash_write;
    logic [2:0]               o_download_state;
    logic [MAC_W-1:0]         o_peer_addr;

    int fail_count;
    int pending;
    int checked;
    int sent_count     = 0;
    int settings_count = 0;
    int tick_span      = 8;
    int calm_left[2]   = '{0, 0};
    bit steady         = 1'b0;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    image_download_receiver_unit u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_req_type          (i_req_type),
        .i_command           (i_command),
        .i_seq_num           (i_seq_num),
        .i_payload_len       (i_payload_len),
        .i_checksum_bad      (i_checksum_bad),
        .i_source_addr       (i_source_addr),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_ack_valid         (o_ack_valid),
        .o_ack_command       (o_ack_command),
        .o_ack_error         (o_ack_error),
        .o_ack_info          (o_ack_info),
        .o_accept_payload    (o_accept_payload),
        .o_write_offset      (o_write_offset),
        .o_total_length      (o_total_length),
        .o_start_flash_write (o_start_flash_write),
        .o_download_state    (o_download_state),
        .o_peer_addr         (o_peer_addr)
    );

    idr_result_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .i_in_ready          (o_in_ready),
        .i_req_type          (i_req_type),
        .i_command           (i_command),
        .i_seq_num           (i_seq_num),
        .i_payload_len       (i_payload_len),
        .i_checksum_bad      (i_checksum_bad),
        .i_source_addr       (i_source_addr),
        .i_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .i_ack_valid         (o_ack_valid),
        .i_ack_command       (o_ack_command),
        .i_ack_error         (o_ack_error),
        .i_ack_info          (o_ack_info),
        .i_accept_payload    (o_accept_payload),
        .i_write_offset      (o_write_offset),
        .i_total_length      (o_total_length),
        .i_start_flash_write (o_start_flash_write),
        .i_download_state    (o_download_state),
        .i_peer_addr         (o_peer_addr),
        .o_fail_count        (fail_count),
        .o_pending           (pending),
        .o_checked           (checked)
    );

    // idle cycles before the next request or result, with calm stretches
    function automatic int draw_gap(input int side);
        if (steady) return 0;
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0) calm_left[side] = $urandom_range(8, 40);
        return $urandom_range(0, 9);
    endfunction

    function automatic logic [15:0] rand_seq();
        return 16'($urandom());
    endfunction

    function automatic logic [MAC_W-1:0] rand_mac();
        return MAC_W'({$urandom(), $urandom()});
    endfunction

    // mostly legal lengths, some oversized
    function automatic logic [PLEN_W-1:0] rand_len();
        if ($urandom_range(0, 7) == 0) return PLEN_W'($urandom_range(MAX_PAYLOAD + 1, 2047));
        return PLEN_W'($urandom_range(0, MAX_PAYLOAD));
    endfunction

    // one request on the input channel, entered and left at a falling edge
    task automatic send_req(input logic [1:0] req, input logic [2:0] cmd,
                            input logic [15:0] seq, input logic [PLEN_W-1:0] plen,
                            input logic csum, input logic [MAC_W-1:0] src);
        int gap;
        gap = draw_gap(0);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_command      <= cmd;
        i_seq_num      <= seq;
        i_payload_len  <= plen;
        i_checksum_bad <= csum;
        i_source_addr  <= src;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        sent_count++;
    endtask

    task automatic send_packet(input logic [2:0] cmd, input logic [15:0] seq,
                               input logic [PLEN_W-1:0] plen, input logic csum);
        send_req(REQ_PACKET, cmd, seq, plen, csum, rand_mac());
    endtask

    // tick or flash-done with random don't-care fields
    task automatic send_event(input logic [1:0] req);
        send_req(req, 3'($urandom_range(0, 7)), rand_seq(), PLEN_W'($urandom_range(0, 2047)),
                 1'($urandom_range(0, 1)), rand_mac());
    endtask

    // run of ticks, taken with odds of one in the given number
    task automatic tick_burst(input int odds);
        if ($urandom_range(0, odds - 1) == 0) begin
            repeat ($urandom_range(1, tick_span)) send_event(REQ_TICK);
        end
    endtask

    // wait until every request has been answered and the block is quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_settings(input logic [15:0] idle_to, input logic [15:0] image_to,
                                  input logic [7:0] retry, input int span);
        settle();
        write_reg(CFG_IDLE_TIMEOUT, idle_to);
        write_reg(CFG_IMAGE_TIMEOUT, image_to);
        write_reg(CFG_RETRY_LIMIT, 16'(retry));
        i_cfg_valid <= 1'b0;
        tick_span = span;
        settings_count++;
    endtask

    // well-formed download with random content and the odd fault
    task automatic run_session();
        logic [15:0] next_seq;
        send_packet(CMD_RESET, rand_seq(), rand_len(), 1'($urandom_range(0, 1)));
        tick_burst(4);
        send_packet(CMD_REQUEST, rand_seq(), rand_len(), 1'($urandom_range(0, 1)));
        next_seq = 16'd1;
        repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(0, 15))
                0: send_packet(CMD_IMAGE, next_seq + 16'($urandom_range(1, 65535)),
                               rand_len(), 1'($urandom_range(0, 1)));
                1: tick_burst(1);
                2: send_event(2'($urandom_range(0, 3)));
                default: begin
                    send_packet(CMD_IMAGE, next_seq, rand_len(), 1'($urandom_range(0, 1)));
                    next_seq++;
                end
            endcase
        end
        tick_burst(4);
        send_packet(CMD_END, rand_seq(), rand_len(), $urandom_range(0, 5) == 0);
        tick_burst(4);
        send_event(REQ_FDONE);
        tick_burst(4);
        send_packet(CMD_QUERY, rand_seq(), rand_len(), 1'($urandom_range(0, 1)));
    endtask

    // sessions mixed with random noise under one setting
    task automatic run_phase(input logic [15:0] idle_to, input logic [15:0] image_to,
                             input logic [7:0] retry, input int span);
        int goal;
        write_settings(idle_to, image_to, retry, span);
        goal = sent_count + 160;
        while (sent_count < goal) begin
            if ($urandom_range(0, 3) != 0) begin
                run_session();
            end else begin
                repeat ($urandom_range(1, 5)) begin
                    send_req(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), rand_seq(),
                             PLEN_W'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)),
                             rand_mac());
                end
            end
        end
    endtask

    // result side: ready drops for a random number of cycles per result
    initial begin : result_sink
        int gap;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = draw_gap(1);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        logic [15:0] next_seq;
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_req_type     = '0;
        i_command      = '0;
        i_seq_num      = '0;
        i_payload_len  = '0;
        i_checksum_bad = 1'b0;
        i_source_addr  = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed protocol cases at reset settings
        send_req(REQ_TICK, CMD_RESET, 16'h0000, '0, 1'b0, '0);
        send_req(REQ_FDONE, CMD_UNKNOWN_HI, 16'hFFFF, '1, 1'b1, '1);
        send_req(REQ_UNUSED, CMD_IMAGE, 16'h0001, 11'd100, 1'b0, 48'h0123_4567_89AB);
        send_req(REQ_PACKET, CMD_UNKNOWN_LO, 16'h5A5A, '0, 1'b0, '0);
        send_req(REQ_PACKET, CMD_REQUEST, 16'h0007, '0, 1'b0, '0);
        send_req(REQ_PACKET, CMD_RESET, 16'hFFFF, '0, 1'b0, '1);
        send_req(REQ_PACKET, CMD_IMAGE, 16'h0001, 11'd10, 1'b0, '0);
        send_req(REQ_PACKET, CMD_QUERY, 16'h0002, '0, 1'b0, '0);
        send_req(REQ_PACKET, CMD_END, 16'h0003, '0, 1'b1, '0);
        send_req(REQ_PACKET, CMD_REQUEST, 16'h0000, '0, 1'b0, '0);
        send_req(REQ_PACKET, CMD_IMAGE, 16'h0001, 11'd0, 1'b0, '0);
        send_req(REQ_PACKET, CMD_IMAGE, 16'hFFFF, 11'd64, 1'b0, '0);
        send_req(REQ_PACKET, CMD_IMAGE, 16'h0002, '1, 1'b0, '0);
        send_req(REQ_PACKET, CMD_IMAGE, 16'h0003, 11'd1500, 1'b0, '0);
        send_req(REQ_PACKET, CMD_REQUEST, 16'h0004, '0, 1'b0, '0);
        send_req(REQ_PACKET, CMD_END, 16'h0004, '0, 1'b0, '0);
        send_req(REQ_TICK, CMD_RESET, 16'h0000, '0, 1'b0, '0);
        send_req(REQ_PACKET, CMD_IMAGE, 16'h0004, 11'd8, 1'b0, '0);
        send_req(REQ_FDONE, CMD_RESET, 16'h0000, '0, 1'b0, '0);
        send_req(REQ_FDONE, CMD_RESET, 16'h0000, '0, 1'b0, '0);
        send_req(REQ_PACKET, CMD_QUERY, 16'h0005, '0, 1'b0, '0);
        send_req(REQ_PACKET, CMD_REQUEST, 16'h0006, '0, 1'b0, '0);
        send_req(REQ_PACKET, CMD_IMAGE, 16'h0001, 11'h3FF, 1'b0, '0);
        send_req(REQ_PACKET, CMD_END, 16'h0002, '0, 1'b1, '0);
        send_req(REQ_PACKET, CMD_UNKNOWN_HI, 16'h0000, '0, 1'b1, '0);

        // random sessions across timeout and retry settings, extremes included
        run_phase(16'd100, 16'd100, 8'd5, 8);
        run_phase(16'd1, 16'd1, 8'd1, 4);
        run_phase(16'd0, 16'd0, 8'd255, 6);
        run_phase(16'd3, 16'd2, 8'd3, 20);
        run_phase(16'hFFFF, 16'hFFFF, 8'd1, 4);
        run_phase(16'd1, 16'd1, 8'd255, 300);
        run_phase(16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                  8'($urandom_range(1, 6)), 30);
        run_phase(16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                  8'($urandom_range(1, 6)), 30);

        // back-to-back transfer with full-size and oversized payloads
        write_settings(16'd0, 16'd0, 8'd1, 1);
        steady = 1'b1;
        send_packet(CMD_RESET, rand_seq(), rand_len(), 1'b0);
        send_packet(CMD_REQUEST, rand_seq(), rand_len(), 1'b0);
        next_seq = 16'd1;
        for (int n = 0; n < LONG_IMAGES; n++) begin
            send_packet(CMD_IMAGE, next_seq, n[0] ? PLEN_W'(MAX_PAYLOAD) : '1, 1'b0);
            next_seq++;
        end
        send_packet(CMD_END, rand_seq(), rand_len(), 1'b0);
        send_event(REQ_FDONE);
        send_packet(CMD_QUERY, rand_seq(), rand_len(), 1'b0);
        steady = 1'b0;

        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        $display("covered %0d requests under %0d register settings, %0d results checked",
                 sent_count, settings_count, checked);
        if (fail_count == 0) begin
            $display("[image_download_receiver_unit] OK");
        end else begin
            $display("[image_download_receiver_unit] ERROR");
        end
        $finish;
    end

    // hang guard
    initial begin : watchdog
        #(30_000_000);
        $display("[image_download_receiver_unit] ERROR");
        $finish;
    end

endmodule

@@ image_download_receiver_unit.f @@
rtl/core/idr_pkg.sv
rtl/core/idr_front.sv
rtl/core/idr_queue.sv
rtl/core/idr_back.sv
rtl/core/image_download_receiver_unit.sv
bench/idr_result_checker.sv
bench/tb_top.sv
